// ----- rtl/core/line_follow_pid_drive_core_assert.svh -----
// Assertion macros for the line follower drive core.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef LINE_FOLLOW_PID_DRIVE_CORE_ASSERT_SVH
`define LINE_FOLLOW_PID_DRIVE_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define LFPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lfpd_pkg.sv -----
`timescale 1ns / 1ps

package lfpd_pkg;

  // Default build parameters
  localparam int NUM_SENSORS_DEF = 5;
  localparam int SENSOR_BITS_DEF = 10;

  // Field and register widths
  localparam int GAIN_W     = 20;
  localparam int BASE_W     = 15;
  localparam int LIM_W      = 19;
  localparam int LEAK_W     = 16;
  localparam int ERR_W      = 15;
  localparam int INTEG_W    = 20;
  localparam int DIFF_W     = 16;
  localparam int DRIVE_W    = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  // Register reset values
  localparam int GAIN_PROP_RST  = 64000;
  localparam int GAIN_INTEG_RST = 77;
  localparam int GAIN_DERIV_RST = 102400;
  localparam int BASE_SPEED_RST = 13107;
  localparam int INTEG_LIM_RST  = 409600;
  localparam int INTEG_LEAK_RST = 58982;

  // Serial divider: quotient bits per run, and the correction divisor
  localparam int DIV_QB    = 17;
  localparam int PID_DIV   = 6400;
  localparam int PID_DIV_W = 13;

  // Serial multiplier operand widths and the PID accumulator
  localparam int MUL_AW = 20;
  localparam int MUL_BW = 20;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int PID_W  = PROD_W + 3;

  // Fixed-point shifts and limits
  localparam int ERR_FRAC_SH = 11;
  localparam int LEAK_SH     = 16;
  localparam int ERR_MAX     = 16383;
  localparam int DRIVE_MAX   = 16384;
  localparam int CORR_W      = DIV_QB;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INTEG = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_BASE_SPEED = 3'd3,
    CFG_INTEG_LIM  = 3'd4,
    CFG_INTEG_LEAK = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_EDIV_GO,
    ST_EDIV_WAIT,
    ST_LEAK_GO,
    ST_LEAK_WAIT,
    ST_PID_GO,
    ST_PID_WAIT,
    ST_CDIV_GO,
    ST_CDIV_WAIT,
    ST_DRIVE
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/core/line_follow_pid_drive_core.sv -----
// An accepted item goes into the sums one sensor per cycle, then through an error divide,
// a leak multiply, three term multiplies and a correction divide on the shared serial units;
// the error divide is skipped when the line is lost and the correction divide when the
// correction saturates. A new item is taken only once the last result has been loaded.
// Reset (synchronous, rst_n low): registers take their default gains, the integral and the
// previous error clear to zero, and the output channel empties.
`timescale 1ns / 1ps
`include "line_follow_pid_drive_core_assert.svh"

module line_follow_pid_drive_core #(
  parameter int NUM_SENSORS = lfpd_pkg::NUM_SENSORS_DEF,
  parameter int SENSOR_BITS = lfpd_pkg::SENSOR_BITS_DEF,
  localparam int IN_W       = NUM_SENSORS * SENSOR_BITS,
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: sensor_0, sensor_1, ... sensor_N-1, SENSOR_BITS each, then zero fill
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  // out_tdata: left_drive [15:0], right_drive [31:16]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*lfpd_pkg::DRIVE_W-1:0]  out_tdata,
  // out_tuser: line_lost
  output logic                            out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(NUM_SENSORS);
  localparam int WT_W   = IDX_W + 1;
  localparam int TOT_W  = SENSOR_BITS + $clog2(NUM_SENSORS);
  localparam int WSUM_W = TOT_W + $clog2(NUM_SENSORS) + 1;
  localparam int EDVD_W = WSUM_W + lfpd_pkg::ERR_FRAC_SH;
  localparam int DVW    = (TOT_W > lfpd_pkg::PID_DIV_W) ? TOT_W : lfpd_pkg::PID_DIV_W;
  localparam int DRV_W  = lfpd_pkg::BASE_W + 4;
  localparam int ACC_W  = lfpd_pkg::INTEG_W + 1;

  localparam int ERR_W   = lfpd_pkg::ERR_W;
  localparam int INTEG_W = lfpd_pkg::INTEG_W;
  localparam int DIFF_W  = lfpd_pkg::DIFF_W;
  localparam int PID_W   = lfpd_pkg::PID_W;
  localparam int PROD_W  = lfpd_pkg::PROD_W;
  localparam int DIV_QB  = lfpd_pkg::DIV_QB;
  localparam int CORR_W  = lfpd_pkg::CORR_W;
  localparam int DRIVE_W = lfpd_pkg::DRIVE_W;

  // Configuration registers
  logic [lfpd_pkg::GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [lfpd_pkg::BASE_W-1:0] base_speed_r;
  logic [lfpd_pkg::LIM_W-1:0]  integ_limit_r;
  logic [lfpd_pkg::LEAK_W-1:0] integ_leak_r;

  // Control and carried state
  lfpd_pkg::state_t state_r, state_nxt;
  lfpd_pkg::term_t  term_r, term_nxt;
  logic [IDX_W-1:0] idx_r;
  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [INTEG_W-1:0] integ_acc_r;
  logic out_tvalid_r, out_tvalid_nxt;

  // Working registers
  logic [SENSOR_BITS-1:0]    sens_r [NUM_SENSORS];
  logic [TOT_W-1:0]          tot_r;
  logic signed [WSUM_W-1:0]  wsum_r;
  logic signed [ERR_W-1:0]   err_r;
  logic                      lost_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [PID_W-1:0]   pid_acc_r;
  logic                      corr_neg_r;
  logic [CORR_W-1:0]         corr_mag_r;
  logic [2*DRIVE_W-1:0]      out_tdata_r;
  logic                      out_tuser_r;

  // Unit handshakes
  logic                       div_start, mul_start, out_load, out_free;
  lfpd_pkg::unit_sts_t        div_sts, mul_sts;
  logic [DVW-1:0]             div_dvs, div_rem_init;
  logic [DIV_QB-1:0]          div_low, div_quo;
  logic [lfpd_pkg::MUL_AW-1:0] mul_a;
  logic [lfpd_pkg::MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0]          mul_prod;

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= lfpd_pkg::GAIN_W'(lfpd_pkg::GAIN_PROP_RST);
      gain_integ_r  <= lfpd_pkg::GAIN_W'(lfpd_pkg::GAIN_INTEG_RST);
      gain_deriv_r  <= lfpd_pkg::GAIN_W'(lfpd_pkg::GAIN_DERIV_RST);
      base_speed_r  <= lfpd_pkg::BASE_W'(lfpd_pkg::BASE_SPEED_RST);
      integ_limit_r <= lfpd_pkg::LIM_W'(lfpd_pkg::INTEG_LIM_RST);
      integ_leak_r  <= lfpd_pkg::LEAK_W'(lfpd_pkg::INTEG_LEAK_RST);
    end else if (cfg_wr_en) begin
      unique case (lfpd_pkg::cfg_idx_t'(cfg_index))
        lfpd_pkg::CFG_GAIN_PROP:  gain_prop_r   <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_GAIN_INTEG: gain_integ_r  <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_GAIN_DERIV: gain_deriv_r  <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::CFG_BASE_SPEED: base_speed_r  <= cfg_wdata[lfpd_pkg::BASE_W-1:0];
        lfpd_pkg::CFG_INTEG_LIM:  integ_limit_r <= cfg_wdata[lfpd_pkg::LIM_W-1:0];
        lfpd_pkg::CFG_INTEG_LEAK: integ_leak_r  <= cfg_wdata[lfpd_pkg::LEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Centroid sums: weight of the sensor at the head of the shift line
  logic signed [WT_W-1:0]          wt;
  logic signed [WT_W+SENSOR_BITS:0] ws_prod;

  assign wt      = $signed(WT_W'({idx_r, 1'b0}) - WT_W'(NUM_SENSORS - 1));
  assign ws_prod = wt * $signed({1'b0, sens_r[0]});

  // Error dividend |wsum| * 2048, split for the divider
  logic [WSUM_W-1:0] wsum_abs;
  logic [EDVD_W-1:0] edvd, edvd_top;

  assign wsum_abs = wsum_r[WSUM_W-1] ? WSUM_W'(0) - wsum_r : wsum_r;
  assign edvd     = {wsum_abs, {lfpd_pkg::ERR_FRAC_SH{1'b0}}};
  assign edvd_top = edvd >> DIV_QB;

  // Saturate the centroid quotient and restore its sign
  logic signed [ERR_W-1:0] err_q;
  always_comb begin
    if (wsum_r[WSUM_W-1]) begin
      err_q = $signed(ERR_W'(0) - div_quo[ERR_W-1:0]);
    end else if (div_quo > DIV_QB'(lfpd_pkg::ERR_MAX)) begin
      err_q = ERR_W'(lfpd_pkg::ERR_MAX);
    end else begin
      err_q = $signed(div_quo[ERR_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Leaky integral: truncate |acc| * leak / 65536, restore sign, add error, clamp
  logic [INTEG_W-1:0]       acc_abs, leak_mag;
  logic signed [ACC_W-1:0]  leak_s, integ_sum, lim_s, integ_clamp;

  assign acc_abs   = integ_acc_r[INTEG_W-1] ? INTEG_W'(0) - integ_acc_r : integ_acc_r;
  assign leak_mag  = mul_prod[lfpd_pkg::LEAK_SH+INTEG_W-1:lfpd_pkg::LEAK_SH];
  assign leak_s    = integ_acc_r[INTEG_W-1] ? $signed(ACC_W'(0) - {1'b0, leak_mag})
                                            : $signed({1'b0, leak_mag});
  assign integ_sum = leak_s + ACC_W'(err_r);
  assign lim_s     = $signed(ACC_W'(integ_limit_r));

  always_comb begin
    priority if (integ_sum > lim_s) begin
      integ_clamp = lim_s;
    end else if (integ_sum < -lim_s) begin
      integ_clamp = -lim_s;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // PID term operands
  logic [lfpd_pkg::GAIN_W-1:0] term_gain;
  logic signed [INTEG_W-1:0]   term_val;
  logic [INTEG_W-1:0]          term_abs;
  logic signed [PID_W-1:0]     pid_add;

  always_comb begin
    unique case (term_r)
      lfpd_pkg::TERM_P: begin
        term_gain = gain_prop_r;
        term_val  = INTEG_W'(err_r);
      end
      lfpd_pkg::TERM_I: begin
        term_gain = gain_integ_r;
        term_val  = integ_r;
      end
      lfpd_pkg::TERM_D: begin
        term_gain = gain_deriv_r;
        term_val  = INTEG_W'(diff_r);
      end
      default: begin
        term_gain = gain_deriv_r;
        term_val  = INTEG_W'(diff_r);
      end
    endcase
  end

  assign term_abs = term_val[INTEG_W-1] ? INTEG_W'(0) - term_val : term_val;
  assign pid_add  = $signed(PID_W'(mul_prod));

  always_comb begin
    unique case (term_r)
      lfpd_pkg::TERM_P: term_nxt = lfpd_pkg::TERM_I;
      lfpd_pkg::TERM_I: term_nxt = lfpd_pkg::TERM_D;
      default:          term_nxt = lfpd_pkg::TERM_P;
    endcase
  end

  // Correction dividend |pid|, split for the divider; flag a quotient past 17 bits
  logic [PID_W-1:0] pid_abs, pid_top;
  logic             corr_ovf;

  assign pid_abs  = pid_acc_r[PID_W-1] ? PID_W'(0) - pid_acc_r : pid_acc_r;
  assign pid_top  = pid_abs >> DIV_QB;
  assign corr_ovf = (pid_top >= PID_W'(lfpd_pkg::PID_DIV));

  // ---------------------------------------------------------------------------
  // Wheel drives: base -/+ correction, saturated to full scale
  logic signed [DRV_W-1:0]   base_s, corr_s, left_raw, right_raw;
  logic signed [DRIVE_W-1:0] left_sat, right_sat;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [DRV_W-1:0] v);
    logic signed [DRIVE_W-1:0] r;
    priority if (v > $signed(DRV_W'(lfpd_pkg::DRIVE_MAX))) begin
      r = DRIVE_W'(lfpd_pkg::DRIVE_MAX);
    end else if (v < -$signed(DRV_W'(lfpd_pkg::DRIVE_MAX))) begin
      r = -$signed(DRIVE_W'(lfpd_pkg::DRIVE_MAX));
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

  assign base_s    = $signed(DRV_W'(base_speed_r));
  assign corr_s    = corr_neg_r ? $signed(DRV_W'(0) - DRV_W'(corr_mag_r))
                                : $signed(DRV_W'(corr_mag_r));
  assign left_raw  = base_s - corr_s;
  assign right_raw = base_s + corr_s;
  assign left_sat  = sat_drive(left_raw);
  assign right_sat = sat_drive(right_raw);

  // ---------------------------------------------------------------------------
  // Shared unit operand selection
  always_comb begin
    if (state_r == lfpd_pkg::ST_EDIV_GO) begin
      div_dvs      = DVW'(tot_r);
      div_rem_init = edvd_top[DVW-1:0];
      div_low      = edvd[DIV_QB-1:0];
    end else begin
      div_dvs      = DVW'(lfpd_pkg::PID_DIV);
      div_rem_init = pid_top[DVW-1:0];
      div_low      = pid_abs[DIV_QB-1:0];
    end
  end

  always_comb begin
    if (state_r == lfpd_pkg::ST_LEAK_GO) begin
      mul_a = lfpd_pkg::MUL_AW'(integ_leak_r);
      mul_b = acc_abs;
    end else begin
      mul_a = term_gain;
      mul_b = term_abs;
    end
  end

  lfpd_serial_div #(
    .DVW (DVW),
    .QB  (DIV_QB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_dvs),
    .rem_init (div_rem_init),
    .low_bits (div_low),
    .quo      (div_quo),
    .sts      (div_sts)
  );

  lfpd_serial_mul #(
    .AW (lfpd_pkg::MUL_AW),
    .BW (lfpd_pkg::MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfpd_pkg::ST_IDLE:
        if (in_tvalid) state_nxt = lfpd_pkg::ST_SUM;
      lfpd_pkg::ST_SUM:
        if (idx_r == IDX_W'(NUM_SENSORS - 1)) state_nxt = lfpd_pkg::ST_EDIV_GO;
      lfpd_pkg::ST_EDIV_GO:
        state_nxt = (tot_r == '0) ? lfpd_pkg::ST_LEAK_GO : lfpd_pkg::ST_EDIV_WAIT;
      lfpd_pkg::ST_EDIV_WAIT:
        if (div_sts.done) state_nxt = lfpd_pkg::ST_LEAK_GO;
      lfpd_pkg::ST_LEAK_GO:
        state_nxt = lfpd_pkg::ST_LEAK_WAIT;
      lfpd_pkg::ST_LEAK_WAIT:
        if (mul_sts.done) state_nxt = lfpd_pkg::ST_PID_GO;
      lfpd_pkg::ST_PID_GO:
        state_nxt = lfpd_pkg::ST_PID_WAIT;
      lfpd_pkg::ST_PID_WAIT:
        if (mul_sts.done) begin
          state_nxt = (term_r == lfpd_pkg::TERM_D) ? lfpd_pkg::ST_CDIV_GO
                                                   : lfpd_pkg::ST_PID_GO;
        end
      lfpd_pkg::ST_CDIV_GO:
        state_nxt = corr_ovf ? lfpd_pkg::ST_DRIVE : lfpd_pkg::ST_CDIV_WAIT;
      lfpd_pkg::ST_CDIV_WAIT:
        if (div_sts.done) state_nxt = lfpd_pkg::ST_DRIVE;
      lfpd_pkg::ST_DRIVE:
        if (out_free) state_nxt = lfpd_pkg::ST_IDLE;
      default:
        state_nxt = lfpd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      lfpd_pkg::ST_IDLE:    in_tready = 1'b1;
      lfpd_pkg::ST_EDIV_GO: div_start = (tot_r != '0);
      lfpd_pkg::ST_LEAK_GO: mul_start = 1'b1;
      lfpd_pkg::ST_PID_GO:  mul_start = 1'b1;
      lfpd_pkg::ST_CDIV_GO: div_start = !corr_ovf;
      lfpd_pkg::ST_DRIVE:   out_load  = out_free;
      default: ;
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers and carried state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lfpd_pkg::ST_IDLE;
      term_r       <= lfpd_pkg::TERM_P;
      idx_r        <= '0;
      last_error_r <= '0;
      integ_acc_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (in_tvalid && in_tready) begin
        idx_r <= '0;
      end else if (state_r == lfpd_pkg::ST_SUM) begin
        idx_r <= idx_r + 1'b1;
      end
      if (state_r == lfpd_pkg::ST_LEAK_WAIT && mul_sts.done) begin
        term_r <= lfpd_pkg::TERM_P;
      end else if (state_r == lfpd_pkg::ST_PID_WAIT && mul_sts.done) begin
        term_r <= term_nxt;
      end
      // Commit error and integral together with the result
      if (out_load) begin
        last_error_r <= err_r;
        integ_acc_r  <= integ_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      lfpd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < NUM_SENSORS; i++) begin
            sens_r[i] <= in_tdata[i*SENSOR_BITS +: SENSOR_BITS];
          end
          tot_r  <= '0;
          wsum_r <= '0;
        end
      end
      lfpd_pkg::ST_SUM: begin
        // Take one sensor into the sums and advance the shift line
        tot_r  <= tot_r + TOT_W'(sens_r[0]);
        wsum_r <= wsum_r + WSUM_W'(ws_prod);
        for (int i = 0; i < NUM_SENSORS - 1; i++) begin
          sens_r[i] <= sens_r[i+1];
        end
      end
      lfpd_pkg::ST_EDIV_GO: begin
        lost_r <= (tot_r == '0);
        if (tot_r == '0) begin
          err_r <= last_error_r;
        end
      end
      lfpd_pkg::ST_EDIV_WAIT: begin
        if (div_sts.done) begin
          err_r <= err_q;
        end
      end
      lfpd_pkg::ST_LEAK_WAIT: begin
        if (mul_sts.done) begin
          integ_r   <= integ_clamp[INTEG_W-1:0];
          diff_r    <= DIFF_W'(err_r) - DIFF_W'(last_error_r);
          pid_acc_r <= '0;
        end
      end
      lfpd_pkg::ST_PID_WAIT: begin
        if (mul_sts.done) begin
          pid_acc_r <= term_val[INTEG_W-1] ? pid_acc_r - pid_add : pid_acc_r + pid_add;
        end
      end
      lfpd_pkg::ST_CDIV_GO: begin
        corr_neg_r <= pid_acc_r[PID_W-1];
        if (corr_ovf) begin
          corr_mag_r <= '1;
        end
      end
      lfpd_pkg::ST_CDIV_WAIT: begin
        if (div_sts.done) begin
          corr_mag_r <= div_quo;
        end
      end
      lfpd_pkg::ST_DRIVE: begin
        if (out_free) begin
          out_tdata_r <= {right_sat, left_sat};
          out_tuser_r <= lost_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Assertions
  `LFPD_ASSERT_SAME(a_div_busy_state, div_sts.busy, state_r == lfpd_pkg::ST_EDIV_WAIT || state_r == lfpd_pkg::ST_CDIV_WAIT, "divider runs outside a divide wait")
  `LFPD_ASSERT_SAME(a_mul_busy_state, mul_sts.busy, state_r == lfpd_pkg::ST_LEAK_WAIT || state_r == lfpd_pkg::ST_PID_WAIT, "multiplier runs outside a multiply wait")
  `LFPD_ASSERT_NEXT(a_accept_to_sum, in_tvalid && in_tready, state_r == lfpd_pkg::ST_SUM && idx_r == '0, "accepted item did not start the sums")

endmodule

// ----- rtl/core/lfpd_serial_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller hands in the
// dividend as a top part (below the divisor) and QB low bits.
module lfpd_serial_div #(
  parameter int DVW = lfpd_pkg::PID_DIV_W,
  parameter int QB  = lfpd_pkg::DIV_QB
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVW-1:0]      divisor,
  input  logic [DVW-1:0]      rem_init,
  input  logic [QB-1:0]       low_bits,
  output logic [QB-1:0]       quo,
  output lfpd_pkg::unit_sts_t sts
);

  localparam int CNT_W = $clog2(QB + 1);

  logic [DVW-1:0]   dvs_r;
  logic [DVW-1:0]   rem_r, rem_nxt;
  logic [QB-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVW:0]     trial, trial_sub;
  logic             ge;

  // Bring down the next dividend bit and try the subtraction
  assign trial     = {rem_r, sh_r[QB-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign rem_nxt   = ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
  assign sh_nxt    = {sh_r[QB-2:0], ge};

  // Sequence the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then step remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= rem_init;
      sh_r  <= low_bits;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign quo      = sh_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- rtl/core/lfpd_serial_mul.sv -----
`timescale 1ns / 1ps

// Shift-add multiplier on unsigned operands, one multiplier bit per cycle.
module lfpd_serial_mul #(
  parameter int AW = lfpd_pkg::MUL_AW,
  parameter int BW = lfpd_pkg::MUL_BW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       op_a,
  input  logic [BW-1:0]       op_b,
  output logic [AW+BW-1:0]    prod,
  output lfpd_pkg::unit_sts_t sts
);

  localparam int CNT_W = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [AW:0]      upper;

  // Add the multiplicand when the low multiplier bit is set, then shift right
  assign upper    = {1'b0, prod_r[AW+BW-1:BW]} + {1'b0, (prod_r[0] ? a_r : '0)};
  assign prod_nxt = {upper, prod_r[BW-1:1]};

  // Sequence the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then step the partial product
  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= op_a;
      prod_r <= {{AW{1'b0}}, op_b};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod     = prod_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- sim/line_follow_pid_drive_core_test.sv -----
`timescale 1ns / 1ps

module line_follow_pid_drive_core_test;

  localparam int NS         = lfpd_pkg::NUM_SENSORS_DEF;
  localparam int SB         = lfpd_pkg::SENSOR_BITS_DEF;
  localparam int DW         = lfpd_pkg::DRIVE_W;
  localparam int CW         = lfpd_pkg::CFG_DATA_W;
  localparam int SMAX       = (1 << SB) - 1;
  localparam int IN_TDATA_W = ((NS * SB + 7) / 8) * 8;
  localparam int RAND_ITEMS = 122;
  localparam int NUM_PHASES = 8;
  localparam int LONG_HOLD  = 3000;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 200;

  typedef struct {
    logic signed [DW-1:0] left;
    logic signed [DW-1:0] right;
    logic                 lost;
  } drive_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [IN_TDATA_W-1:0]            in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [2*DW-1:0]                  out_tdata;
  logic                             out_tuser;
  logic                             cfg_wr_en  = 1'b0;
  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CW-1:0]                    cfg_wdata  = '0;

  // Shadow registers and controller state
  longint gain_p     = lfpd_pkg::GAIN_PROP_RST;
  longint gain_i     = lfpd_pkg::GAIN_INTEG_RST;
  longint gain_d     = lfpd_pkg::GAIN_DERIV_RST;
  longint base_spd   = lfpd_pkg::BASE_SPEED_RST;
  longint clamp_lim  = lfpd_pkg::INTEG_LIM_RST;
  longint leak_fac   = lfpd_pkg::INTEG_LEAK_RST;
  longint prev_err   = 0;
  longint integ_sum  = 0;

  logic [IN_TDATA_W-1:0] sample_q[$];
  drive_t                drive_q[$];
  bit                    tx_busy        = 1'b0;
  bit                    calm           = 1'b0;
  bit                    long_hold_req  = 1'b0;
  bit                    long_hold_done = 1'b0;
  int                    tx_gap         = 0;
  int                    rx_stall       = 0;
  int                    mismatch_count = 0;
  int                    idle_cycles    = 0;
  int                    line_pos       = 2;

  line_follow_pid_drive_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_ll(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the wheel drives for one sensor sample and advance the PID state
  function automatic drive_t predict_drive(logic [IN_TDATA_W-1:0] word);
    longint wsum, total, s, err, integ, diff, pid, corr, lft, rgt;
    int i;
    drive_t r;
    wsum  = 0;
    total = 0;
    for (i = 0; i < NS; i++) begin
      s = word[i*SB +: SB];
      wsum += (2 * i - (NS - 1)) * s;
      total += s;
    end
    r.lost = (total == 0);
    if (r.lost) begin
      err = prev_err;
    end else begin
      err = clamp_ll((wsum * 4096) / (2 * total), -16384, lfpd_pkg::ERR_MAX);
    end
    integ = clamp_ll((integ_sum * leak_fac) / 65536 + err, -clamp_lim, clamp_lim);
    diff  = err - prev_err;
    pid   = gain_p * err + gain_i * integ + gain_d * diff;
    corr  = pid / lfpd_pkg::PID_DIV;
    lft   = clamp_ll(base_spd - corr, -lfpd_pkg::DRIVE_MAX, lfpd_pkg::DRIVE_MAX);
    rgt   = clamp_ll(base_spd + corr, -lfpd_pkg::DRIVE_MAX, lfpd_pkg::DRIVE_MAX);
    integ_sum = integ;
    prev_err  = err;
    r.left  = lft[DW-1:0];
    r.right = rgt[DW-1:0];
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] sample(int a, int b, int c, int d, int e);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[0*SB +: SB] = a[SB-1:0];
    w[1*SB +: SB] = b[SB-1:0];
    w[2*SB +: SB] = c[SB-1:0];
    w[3*SB +: SB] = d[SB-1:0];
    w[4*SB +: SB] = e[SB-1:0];
    return w;
  endfunction

  // Mostly a line seen around a drifting position, plus lost line and noise
  function automatic logic [IN_TDATA_W-1:0] random_sample();
    logic [IN_TDATA_W-1:0] w;
    int r, i, v, off;
    w = '0;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 3) line_pos = $urandom_range(0, NS - 1);
    for (i = 0; i < NS; i++) begin
      if (r < 12) begin
        v = 0;
      end else if (r < 27) begin
        v = $urandom_range(0, SMAX);
      end else if (r < 35) begin
        v = $urandom_range(0, 1) ? SMAX : 0;
      end else begin
        off = (i > line_pos) ? i - line_pos : line_pos - i;
        if (off == 0) v = $urandom_range(500, SMAX);
        else if (off == 1) v = $urandom_range(0, 500);
        else v = $urandom_range(0, 40);
      end
      w[i*SB +: SB] = v[SB-1:0];
    end
    return w;
  endfunction

  // Mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  task automatic cfg_write(lfpd_pkg::cfg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lfpd_pkg::CFG_GAIN_PROP:  gain_p    = val[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::CFG_GAIN_INTEG: gain_i    = val[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::CFG_GAIN_DERIV: gain_d    = val[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::CFG_BASE_SPEED: base_spd  = val[lfpd_pkg::BASE_W-1:0];
      lfpd_pkg::CFG_INTEG_LIM:  clamp_lim = val[lfpd_pkg::LIM_W-1:0];
      lfpd_pkg::CFG_INTEG_LEAK: leak_fac  = val[lfpd_pkg::LEAK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int ph);
    case (ph)
      1: begin
        // all ones: masking of the narrow registers, saturated drives
        cfg_write(lfpd_pkg::CFG_GAIN_PROP, 20'hFFFFF);
        cfg_write(lfpd_pkg::CFG_GAIN_INTEG, 20'hFFFFF);
        cfg_write(lfpd_pkg::CFG_GAIN_DERIV, 20'hFFFFF);
        cfg_write(lfpd_pkg::CFG_BASE_SPEED, 20'hFFFFF);
        cfg_write(lfpd_pkg::CFG_INTEG_LIM, 20'hFFFFF);
        cfg_write(lfpd_pkg::CFG_INTEG_LEAK, 20'hFFFFF);
      end
      2: begin
        cfg_write(lfpd_pkg::CFG_GAIN_PROP, '0);
        cfg_write(lfpd_pkg::CFG_GAIN_INTEG, '0);
        cfg_write(lfpd_pkg::CFG_GAIN_DERIV, '0);
        cfg_write(lfpd_pkg::CFG_BASE_SPEED, '0);
        cfg_write(lfpd_pkg::CFG_INTEG_LIM, '0);
        cfg_write(lfpd_pkg::CFG_INTEG_LEAK, '0);
      end
      NUM_PHASES - 1: begin
        cfg_write(lfpd_pkg::CFG_GAIN_PROP, CW'(lfpd_pkg::GAIN_PROP_RST));
        cfg_write(lfpd_pkg::CFG_GAIN_INTEG, CW'(lfpd_pkg::GAIN_INTEG_RST));
        cfg_write(lfpd_pkg::CFG_GAIN_DERIV, CW'(lfpd_pkg::GAIN_DERIV_RST));
        cfg_write(lfpd_pkg::CFG_BASE_SPEED, CW'(lfpd_pkg::BASE_SPEED_RST));
        cfg_write(lfpd_pkg::CFG_INTEG_LIM, CW'(lfpd_pkg::INTEG_LIM_RST));
        cfg_write(lfpd_pkg::CFG_INTEG_LEAK, CW'(lfpd_pkg::INTEG_LEAK_RST));
      end
      default: begin
        cfg_write(lfpd_pkg::CFG_GAIN_PROP,
                  CW'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)));
        cfg_write(lfpd_pkg::CFG_GAIN_INTEG,
                  CW'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)));
        cfg_write(lfpd_pkg::CFG_GAIN_DERIV,
                  CW'($urandom_range(0, 20'hFFFFF) >> $urandom_range(0, 19)));
        cfg_write(lfpd_pkg::CFG_BASE_SPEED,
                  CW'(($urandom_range(0, 7) == 0) ? $urandom_range(16385, 20'hFFFFF)
                                                  : $urandom_range(0, lfpd_pkg::DRIVE_MAX)));
        cfg_write(lfpd_pkg::CFG_INTEG_LIM, CW'($urandom_range(0, 20'hFFFFF)));
        cfg_write(lfpd_pkg::CFG_INTEG_LEAK, CW'($urandom_range(0, 16'hFFFF)));
      end
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every item is out and the block has settled
  task automatic drain();
    while (sample_q.size() != 0 || tx_busy || drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Stimulus: reset, directed samples, then random phases with new settings
  initial begin
    int ph, n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    sample_q.push_back(sample(0, 0, 0, 0, 0));
    sample_q.push_back(sample(SMAX, SMAX, SMAX, SMAX, SMAX));
    sample_q.push_back(sample(SMAX, 0, 0, 0, 0));
    sample_q.push_back(sample(0, 0, 0, 0, SMAX));
    sample_q.push_back(sample(0, 0, 0, 0, 0));
    sample_q.push_back(sample(1, 0, 0, 0, 0));
    sample_q.push_back(sample(0, 0, 0, 0, 1));
    sample_q.push_back(sample(SMAX, SMAX, 0, 0, 0));
    sample_q.push_back(sample(0, 0, 0, 0, 0));
    sample_q.push_back(sample('h2AA, 'h2AA, 'h2AA, 'h2AA, 'h2AA));
    sample_q.push_back(sample('h155, 'h155, 'h155, 'h155, 'h155));
    sample_q.push_back(sample(SMAX, 0, 0, 0, 1));
    sample_q.push_back(sample(SMAX, 1, 0, 0, 0));
    // one-sided line: drive the integral toward its clamp
    repeat (6) sample_q.push_back(sample(0, 0, 0, SMAX, SMAX));
    sample_q.push_back(sample(0, 0, SMAX, 0, 0));
    sample_q.push_back(sample(1, 1, 1, 1, 1));
    sample_q.push_back(sample(0, 0, 0, 0, 0));
    drain();

    for (ph = 1; ph < NUM_PHASES; ph++) begin
      configure(ph);
      calm          = (ph == 4);
      long_hold_req = (ph == 3);
      for (n = 0; n < RAND_ITEMS; n++) sample_q.push_back(random_sample());
      drain();
    end

    if (drive_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Drive input items from the pending queue, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drive_q.push_back(predict_drive(in_tdata));
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_tdata  <= sample_q.pop_front();
          in_tvalid <= 1'b1;
          tx_busy = 1'b1;
          tx_gap  = calm ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check results against the oldest expectation, stall the output at random
  always @(posedge clk) begin
    drive_t exp_drv;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t unexpected result: left %0d right %0d line_lost %0b", $time,
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tuser);
          mismatch_count++;
        end else begin
          exp_drv = drive_q.pop_front();
          if (out_tdata[15:0] !== exp_drv.left) begin
            $display("%0t left_drive mismatch: expected %0d, got %0d", $time,
                     exp_drv.left, $signed(out_tdata[15:0]));
            mismatch_count++;
          end
          if (out_tdata[31:16] !== exp_drv.right) begin
            $display("%0t right_drive mismatch: expected %0d, got %0d", $time,
                     exp_drv.right, $signed(out_tdata[31:16]));
            mismatch_count++;
          end
          if (out_tuser !== exp_drv.lost) begin
            $display("%0t line_lost mismatch: expected %0b, got %0b", $time,
                     exp_drv.lost, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_stall = LONG_HOLD;
      end else if (rx_stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
